/* hdl/cwm_pkg.sv */
// Shared types, constants and helper functions of the circular window median filter.
`timescale 1ns / 1ps

package cwm_pkg;

    localparam int MAX_RADIUS  = 8;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int SAMPLE_BITS = 16;

    // One spare row beyond the disc height lets the writer run one item ahead.
    localparam int STORE_ROWS = 2 * MAX_RADIUS + 2;
    localparam int RMOD_BITS  = $clog2(STORE_ROWS);
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
    localparam int ADDR_BITS  = RMOD_BITS + COL_BITS;
    localparam int STORE_DEPTH = STORE_ROWS * MAX_WIDTH;
    localparam int RAD_BITS   = $clog2(MAX_RADIUS + 1);
    localparam int DIM_BITS   = $clog2(MAX_WIDTH + 1);
    localparam int WIN_MAX    = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int CNT_BITS   = $clog2(WIN_MAX + 1);
    localparam int LEAD_BITS  = $clog2(MAX_RADIUS * MAX_WIDTH + 1);
    localparam int PASS_BITS  = $clog2(SAMPLE_BITS + 1);
    localparam int BIT_BITS   = $clog2(SAMPLE_BITS);

    localparam logic [SAMPLE_BITS-1:0] BIAS = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef struct packed {
        logic [RAD_BITS-1:0] radius;
        logic [DIM_BITS-1:0] width;
        logic [DIM_BITS-1:0] height;
    } cwm_cfg_t;

    typedef struct packed {
        logic [ROW_BITS-1:0]  row;
        logic [COL_BITS-1:0]  col;
        logic [RMOD_BITS-1:0] rmod;
        logic                 last;
    } cwm_cmd_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ROW,
        B_SCAN,
        B_DRAIN,
        B_PASS,
        B_FIN
    } cwm_bstate_t;

    // Rounded square root of r*r - dy*dy: the largest c with c*(c-1) below it.
    function automatic logic [RAD_BITS-1:0] half_span(input logic [RAD_BITS-1:0] r,
                                                       input logic [RAD_BITS-1:0] dy);
        logic [2*RAD_BITS-1:0] x;
        logic [RAD_BITS-1:0]   c;
        x = (2*RAD_BITS)'(r) * (2*RAD_BITS)'(r) - (2*RAD_BITS)'(dy) * (2*RAD_BITS)'(dy);
        c = '0;
        for (int i = 1; i <= MAX_RADIUS; i++)
        begin
            if ((2*RAD_BITS)'(i * (i - 1)) < x)
            begin
                c = RAD_BITS'(i);
            end
        end
        return c;
    endfunction

    function automatic logic [RMOD_BITS-1:0] rmod_inc(input logic [RMOD_BITS-1:0] m);
        return (m == RMOD_BITS'(STORE_ROWS - 1)) ? '0 : m + 1'b1;
    endfunction

endpackage

/* hdl/cwm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cwm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/cwm_front.sv */
// Front end: accepts words, writes the line store and queues result commands.
`timescale 1ns / 1ps

module cwm_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cwm_pkg::cwm_cfg_t               cfg,
    input  logic                            cfg_restart,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [cwm_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                            flush,
    output logic                            we,
    output logic [cwm_pkg::ADDR_BITS-1:0]   waddr,
    output logic [cwm_pkg::SAMPLE_BITS-1:0] wdata,
    output logic                            cmd_valid,
    output cwm_pkg::cwm_cmd_t               cmd,
    input  logic                            cmd_pop
);
    import cwm_pkg::*;

    logic [COL_BITS-1:0]  in_col_reg, in_col_next;
    logic [ROW_BITS-1:0]  in_row_reg, in_row_next;
    logic [RMOD_BITS-1:0] in_rmod_reg, in_rmod_next;
    logic [COL_BITS-1:0]  out_col_reg, out_col_next;
    logic [ROW_BITS-1:0]  out_row_reg, out_row_next;
    logic [RMOD_BITS-1:0] out_rmod_reg, out_rmod_next;
    logic                 in_done_reg, in_done_next;
    logic [LEAD_BITS-1:0] lead_reg, lead_next;
    logic                 q_vld_reg, q_vld_next;
    cwm_cmd_t             q_reg, q_next;
    logic                 accept, do_emit, last;
    logic [LEAD_BITS-1:0] span;

    assign in_stall  = q_vld_reg;
    assign accept    = in_valid && !q_vld_reg;
    assign span      = LEAD_BITS'(cfg.radius * cfg.width);
    assign waddr     = {in_rmod_reg, in_col_reg};
    assign wdata     = sample;
    assign cmd_valid = q_vld_reg;
    assign cmd       = q_reg;
    assign last      = ({1'b0, out_row_reg} + 1'b1 >= cfg.height) &&
                       ({1'b0, out_col_reg} + 1'b1 >= cfg.width);

    always_comb
    begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_rmod_next  = in_rmod_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_rmod_next = out_rmod_reg;
        in_done_next  = in_done_reg;
        lead_next     = lead_reg;
        q_vld_next    = q_vld_reg;
        q_next        = q_reg;
        we            = 1'b0;
        do_emit       = 1'b0;

        if (cmd_pop)
        begin
            q_vld_next = 1'b0;
        end

        if (cfg_restart)
        begin
            in_col_next   = '0;
            in_row_next   = '0;
            in_rmod_next  = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            out_rmod_next = '0;
            in_done_next  = 1'b0;
            lead_next     = '0;
        end
        else if (accept)
        begin
            if (!flush && !in_done_reg)
            begin
                we = 1'b1;
                if ({1'b0, in_col_reg} + 1'b1 >= cfg.width)
                begin
                    in_col_next  = '0;
                    in_rmod_next = rmod_inc(in_rmod_reg);
                    if ({1'b0, in_row_reg} + 1'b1 >= cfg.height)
                    begin
                        in_row_next  = '0;
                        in_done_next = 1'b1;
                    end
                    else
                    begin
                        in_row_next = in_row_reg + 1'b1;
                    end
                end
                else
                begin
                    in_col_next = in_col_reg + 1'b1;
                end
                if (lead_reg >= span)
                begin
                    do_emit = 1'b1;
                end
                else
                begin
                    lead_next = lead_reg + 1'b1;
                end
            end
            else if (in_done_reg)
            begin
                do_emit = 1'b1;
            end

            if (do_emit)
            begin
                q_vld_next   = 1'b1;
                q_next.row   = out_row_reg;
                q_next.col   = out_col_reg;
                q_next.rmod  = out_rmod_reg;
                q_next.last  = last;
                if ({1'b0, out_col_reg} + 1'b1 >= cfg.width)
                begin
                    out_col_next  = '0;
                    out_row_next  = out_row_reg + 1'b1;
                    out_rmod_next = rmod_inc(out_rmod_reg);
                end
                else
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
                // The last pixel ends the frame; the row slots keep rotating.
                if (last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    in_done_next = 1'b0;
                    lead_next    = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_rmod_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_rmod_reg <= '0;
            in_done_reg  <= 1'b0;
            lead_reg     <= '0;
            q_vld_reg    <= 1'b0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_rmod_reg  <= in_rmod_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_rmod_reg <= out_rmod_next;
            in_done_reg  <= in_done_next;
            lead_reg     <= lead_next;
            q_vld_reg    <= q_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

/* hdl/cwm_back.sv */
// Back end: selects the window median by bitwise rank passes over the line store.
`timescale 1ns / 1ps

module cwm_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cwm_pkg::cwm_cfg_t               cfg,
    input  logic                            cmd_valid,
    input  cwm_pkg::cwm_cmd_t               cmd,
    output logic                            cmd_pop,
    output logic [cwm_pkg::ADDR_BITS-1:0]   raddr,
    input  logic [cwm_pkg::SAMPLE_BITS-1:0] rdata,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [cwm_pkg::SAMPLE_BITS-1:0] median_value,
    output logic                            frame_last
);
    import cwm_pkg::*;

    cwm_bstate_t state_reg, state_next;
    cwm_cmd_t    c_reg, c_next;
    logic [PASS_BITS-1:0]   pass_reg, pass_next;
    logic [ROW_BITS-1:0]    row_reg, row_next, top_reg, top_next, bot_reg, bot_next;
    logic [RMOD_BITS-1:0]   rmod_reg, rmod_next, tmod_reg, tmod_next;
    logic [COL_BITS-1:0]    col_reg, col_next, to_reg, to_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next, k_reg, k_next;
    logic [SAMPLE_BITS-1:0] res_reg, res_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic                   out_vld_reg, out_vld_next;
    logic [SAMPLE_BITS-1:0] med_reg, med_next;
    logic                   last_reg, last_next;

    logic [BIT_BITS-1:0]    bidx;
    logic [SAMPLE_BITS-1:0] mask, bitv;
    logic                   match;
    logic [RAD_BITS-1:0]    d, dy, hs;
    logic [DIM_BITS-1:0]    sum;

    assign bidx  = BIT_BITS'(PASS_BITS'(SAMPLE_BITS) - pass_reg);
    assign mask  = {SAMPLE_BITS{1'b1}} << bidx;
    assign bitv  = {{(SAMPLE_BITS-1){1'b0}}, 1'b1} << bidx;
    assign match = (pass_reg == '0) || ((((rdata ^ BIAS) ^ res_reg) & mask) == '0);
    assign raddr = {rmod_reg, col_reg};

    assign out_valid    = out_vld_reg;
    assign median_value = med_reg;
    assign frame_last   = last_reg;

    always_comb
    begin
        state_next   = state_reg;
        c_next       = c_reg;
        pass_next    = pass_reg;
        row_next     = row_reg;
        top_next     = top_reg;
        bot_next     = bot_reg;
        rmod_next    = rmod_reg;
        tmod_next    = tmod_reg;
        col_next     = col_reg;
        to_next      = to_reg;
        k_next       = k_reg;
        res_next     = res_reg;
        rd_vld_next  = 1'b0;
        med_next     = med_reg;
        last_next    = last_reg;
        out_vld_next = out_vld_reg && out_stall;
        cmd_pop      = 1'b0;
        cnt_next     = cnt_reg + CNT_BITS'(rd_vld_reg && match);
        d            = '0;
        dy           = '0;
        hs           = '0;
        sum          = '0;

        case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    c_next  = cmd;
                    if (cmd.row >= ROW_BITS'(cfg.radius))
                    begin
                        top_next = cmd.row - ROW_BITS'(cfg.radius);
                        d        = cfg.radius;
                    end
                    else
                    begin
                        top_next = '0;
                        d        = RAD_BITS'(cmd.row);
                    end
                    tmod_next = (cmd.rmod >= RMOD_BITS'(d)) ? cmd.rmod - RMOD_BITS'(d)
                              : cmd.rmod + RMOD_BITS'(STORE_ROWS) - RMOD_BITS'(d);
                    sum = {1'b0, cmd.row} + DIM_BITS'(cfg.radius);
                    bot_next  = (sum > cfg.height - 1'b1) ? ROW_BITS'(cfg.height - 1'b1)
                              : ROW_BITS'(sum);
                    row_next  = top_next;
                    rmod_next = tmod_next;
                    pass_next = '0;
                    cnt_next  = '0;
                    res_next  = '0;
                    state_next = B_ROW;
                end
            end
            B_ROW:
            begin
                dy = (row_reg >= c_reg.row) ? RAD_BITS'(row_reg - c_reg.row)
                                            : RAD_BITS'(c_reg.row - row_reg);
                hs = half_span(cfg.radius, dy);
                col_next = (c_reg.col >= COL_BITS'(hs)) ? c_reg.col - COL_BITS'(hs) : '0;
                sum = {1'b0, c_reg.col} + DIM_BITS'(hs);
                to_next = (sum > cfg.width - 1'b1) ? COL_BITS'(cfg.width - 1'b1)
                                                   : COL_BITS'(sum);
                state_next = B_SCAN;
            end
            B_SCAN:
            begin
                rd_vld_next = 1'b1;
                if (col_reg == to_reg)
                begin
                    if (row_reg == bot_reg)
                    begin
                        state_next = B_DRAIN;
                    end
                    else
                    begin
                        row_next   = row_reg + 1'b1;
                        rmod_next  = rmod_inc(rmod_reg);
                        state_next = B_ROW;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            B_DRAIN:
            begin
                state_next = B_PASS;
            end
            B_PASS:
            begin
                // The first pass only counts the window to find the median rank.
                if (pass_reg == '0)
                begin
                    k_next = (cnt_reg - 1'b1) >> 1;
                end
                else if (k_reg >= cnt_reg)
                begin
                    k_next   = k_reg - cnt_reg;
                    res_next = res_reg | bitv;
                end
                cnt_next  = '0;
                pass_next = pass_reg + 1'b1;
                row_next  = top_reg;
                rmod_next = tmod_reg;
                state_next = (pass_reg == PASS_BITS'(SAMPLE_BITS)) ? B_FIN : B_ROW;
            end
            B_FIN:
            begin
                if (!out_vld_reg || !out_stall)
                begin
                    out_vld_next = 1'b1;
                    med_next     = res_reg ^ BIAS;
                    last_next    = c_reg.last;
                    state_next   = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            pass_reg    <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_vld_reg  <= rd_vld_next;
            out_vld_reg <= out_vld_next;
            pass_reg    <= pass_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg    <= c_next;
        row_reg  <= row_next;
        top_reg  <= top_next;
        bot_reg  <= bot_next;
        rmod_reg <= rmod_next;
        tmod_reg <= tmod_next;
        col_reg  <= col_next;
        to_reg   <= to_next;
        k_reg    <= k_next;
        res_reg  <= res_next;
        med_reg  <= med_next;
        last_reg <= last_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_BITS'(WIN_MAX))
        else $error("window count exceeds the disc size");

    a_window_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_PASS && pass_reg == '0) |-> cnt_reg != '0)
        else $error("empty median window");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_FIN && out_vld_reg && out_stall) |=> state_reg == B_FIN)
        else $error("result overwrote a word still waiting at the output");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> state_reg == B_ROW)
        else $error("command taken without starting a window scan");

endmodule

/* hdl/circular_window_median_filter_unit.sv */
// Top level of the circular window median filter: register port, front, back and line store.
//
//  channel  | handshake           | words
//  ---------+---------------------+-------------------------------------
//  input    | in_valid / in_stall | sample, flush
//  output   | out_valid/out_stall | median_value, frame_last
//  config   | APB psel/penable    | radius, image_width, image_height
//
// A result takes 17 passes over its window (n up to 289 samples); each pass reads
// the window through the single read port of the line store.
// The front takes one word per cycle until a result command is queued.
// Reset clears all positions; the line store has no reset.
// A waiting result stalls only the back; the front keeps one command queued.
`timescale 1ns / 1ps

module circular_window_median_filter_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [3:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [cwm_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                            flush,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [cwm_pkg::SAMPLE_BITS-1:0] median_value,
    output logic                            frame_last
);
    import cwm_pkg::*;

    logic [3:0]  radius_reg, radius_next;
    logic [10:0] width_reg, width_next;
    logic [10:0] height_reg, height_next;
    logic        wr, restart;
    logic [1:0]  idx;
    cwm_cfg_t    cfg;
    cwm_cmd_t    cmd;
    logic        cmd_valid, cmd_pop, we;
    logic [ADDR_BITS-1:0]   waddr, raddr;
    logic [SAMPLE_BITS-1:0] wdata, rdata;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr     = psel && penable && pwrite;

    always_comb
    begin
        radius_next = radius_reg;
        width_next  = width_reg;
        height_next = height_reg;
        restart     = 1'b0;
        if (wr)
        begin
            case (idx)
                REG_RADIUS:
                begin
                    radius_next = pwdata[3:0];
                    restart     = 1'b1;
                end
                REG_WIDTH:
                begin
                    width_next = pwdata[10:0];
                    restart    = 1'b1;
                end
                REG_HEIGHT:
                begin
                    height_next = pwdata[10:0];
                    restart     = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_RADIUS: prdata = {28'd0, radius_reg};
            REG_WIDTH:  prdata = {21'd0, width_reg};
            REG_HEIGHT: prdata = {21'd0, height_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 4'd5;
            width_reg  <= 11'd1024;
            height_reg <= 11'd1024;
        end
        else
        begin
            radius_reg <= radius_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // Out-of-range settings are clamped into the supported range.
    always_comb
    begin
        cfg.radius = (radius_reg == '0) ? RAD_BITS'(1)
                   : (radius_reg > 4'(MAX_RADIUS)) ? RAD_BITS'(MAX_RADIUS)
                   : RAD_BITS'(radius_reg);
        cfg.width  = (width_reg == '0) ? DIM_BITS'(1)
                   : (width_reg > 11'(MAX_WIDTH)) ? DIM_BITS'(MAX_WIDTH)
                   : DIM_BITS'(width_reg);
        cfg.height = (height_reg == '0) ? DIM_BITS'(1)
                   : (height_reg > 11'(MAX_HEIGHT)) ? DIM_BITS'(MAX_HEIGHT)
                   : DIM_BITS'(height_reg);
    end

    cwm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cfg_restart (restart),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .flush       (flush),
        .we          (we),
        .waddr       (waddr),
        .wdata       (wdata),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    cwm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    cwm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .raddr        (raddr),
        .rdata        (rdata),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .median_value (median_value),
        .frame_last   (frame_last)
    );

endmodule

/* tb/circular_window_median_filter_unit_test.sv */
// Self-checking testbench of the circular window median filter: random frames, scoreboard.
`timescale 1ns / 1ps

typedef struct {
    logic signed [cwm_pkg::SAMPLE_BITS-1:0] value;
    bit                                     last;
} median_word_t;

class median_scoreboard;
    localparam int ROWS_KEPT = 2 * cwm_pkg::MAX_RADIUS + 1;

    logic signed [cwm_pkg::SAMPLE_BITS-1:0] pixels [0:ROWS_KEPT*cwm_pkg::MAX_WIDTH-1];
    int unsigned  radius_reg, width_reg, height_reg;
    int unsigned  in_row, in_col, out_row, out_col;
    bit           frame_taken;
    median_word_t medians_due [$];
    int           errors;

    function new();
        radius_reg = 5;
        width_reg = 1024;
        height_reg = 1024;
        errors = 0;
        restart();
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    function int unsigned eff_radius();
        return clamp(radius_reg, cwm_pkg::MAX_RADIUS);
    endfunction

    function void restart();
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
        frame_taken = 0;
    endfunction

    function void write_reg(logic [1:0] idx, int unsigned v);
        case (idx)
            cwm_pkg::REG_RADIUS: radius_reg = v & 'hF;
            cwm_pkg::REG_WIDTH:  width_reg = v & 'h7FF;
            cwm_pkg::REG_HEIGHT: height_reg = v & 'h7FF;
            default: return;
        endcase
        restart();
    endfunction

    function int pending();
        return medians_due.size();
    endfunction

    // Rounded half width of a disc row: largest c with c*(c-1) below r*r - dy*dy.
    function int span_of(int r, int dy);
        int x;
        int c;
        x = r * r - dy * dy;
        c = 0;
        while ((c + 1) * c < x)
            c++;
        return c;
    endfunction

    function void release_median();
        int r;
        int w;
        int h;
        int top;
        int bot;
        int from;
        int upto;
        int c;
        int n;
        int k;
        int lower;
        int same;
        logic signed [cwm_pkg::SAMPLE_BITS-1:0] win [$];
        median_word_t m;
        r = eff_radius();
        w = clamp(width_reg, cwm_pkg::MAX_WIDTH);
        h = clamp(height_reg, cwm_pkg::MAX_HEIGHT);
        top = (int'(out_row) - r < 0) ? 0 : int'(out_row) - r;
        bot = (int'(out_row) + r > h - 1) ? h - 1 : int'(out_row) + r;
        for (int row = top; row <= bot; row++)
        begin
            c = span_of(r, (row > int'(out_row)) ? row - int'(out_row) : int'(out_row) - row);
            from = (int'(out_col) - c < 0) ? 0 : int'(out_col) - c;
            upto = (int'(out_col) + c > w - 1) ? w - 1 : int'(out_col) + c;
            for (int col = from; col <= upto; col++)
                win.push_back(pixels[(row % ROWS_KEPT) * cwm_pkg::MAX_WIDTH + col]);
        end
        n = win.size();
        k = (n - 1) / 2;
        // The lower median is the value v with (#below v) <= k < (#below v) + (#equal v).
        foreach (win[i])
        begin
            lower = 0;
            same = 0;
            foreach (win[j])
            begin
                if (win[j] < win[i])
                    lower++;
                else if (win[j] == win[i])
                    same++;
            end
            if (lower <= k && k < lower + same)
                m.value = win[i];
        end
        if (out_row + 1 >= h && out_col + 1 >= w)
        begin
            m.last = 1;
            restart();
        end
        else
        begin
            m.last = 0;
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
        medians_due.push_back(m);
    endfunction

    function void note_word(logic signed [cwm_pkg::SAMPLE_BITS-1:0] s, bit f);
        int unsigned w;
        int unsigned h;
        bit          due;
        w = clamp(width_reg, cwm_pkg::MAX_WIDTH);
        h = clamp(height_reg, cwm_pkg::MAX_HEIGHT);
        if (!f && !frame_taken)
        begin
            due = (in_row * w + in_col) >= (out_row * w + out_col) + eff_radius() * w;
            pixels[(in_row % ROWS_KEPT) * cwm_pkg::MAX_WIDTH + in_col] = s;
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
                if (in_row >= h)
                begin
                    in_row = 0;
                    frame_taken = 1;
                end
            end
            if (due)
                release_median();
        end
        else if (frame_taken)
        begin
            release_median();
        end
    endfunction

    function void check_median(logic signed [cwm_pkg::SAMPLE_BITS-1:0] v, bit l);
        median_word_t m;
        if (medians_due.size() == 0)
        begin
            $error("unexpected result: median_value %0d frame_last %0d", v, l);
            errors++;
            return;
        end
        m = medians_due.pop_front();
        if (v !== m.value)
        begin
            $error("median_value: expected %0d, got %0d", m.value, v);
            errors++;
        end
        if (l !== m.last)
        begin
            $error("frame_last: expected %0d, got %0d", m.last, l);
            errors++;
        end
    endfunction
endclass

module circular_window_median_filter_unit_test;
    import cwm_pkg::*;

    localparam int CYCLE_LIMIT = 20000000;
    localparam int RANDOM_SAMPLES = 1500;

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [3:0]                    paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          in_valid;
    logic                          in_stall;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          flush;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [SAMPLE_BITS-1:0] median_value;
    logic                          frame_last;

    median_scoreboard sb = new();
    bit               quiet = 0;
    int               stall_left = 0;
    int               cycles = 0;
    int               sent = 0;

    circular_window_median_filter_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sample(sample),
        .flush(flush),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .median_value(median_value),
        .frame_last(frame_last)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: take words and stall in random bursts.
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
            sb.check_median(median_value, frame_last);
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 8);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 3))
            0: return SAMPLE_BITS'($urandom_range(0, 8) - 4);
            1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic push_word(logic [SAMPLE_BITS-1:0] s, bit f);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= s;
        flush <= f;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_word(s, f);
    endtask

    // Wait for every due result, then for one result's worth of work in the block.
    task automatic settle();
        int r;
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        r = sb.eff_radius();
        repeat (17 * ((2 * r + 1) * (2 * r + 1) + 2 * r + 4)) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int unsigned v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.write_reg(idx, v);
        @(posedge clk);
    endtask

    // One setting: whole frames with random flushes, then an optional cut-off frame.
    task automatic run_setting(int r, int w, int h, int frames, int partial);
        int cols;
        int rows;
        settle();
        write_reg(REG_RADIUS, r);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        cols = sb.clamp(sb.width_reg, MAX_WIDTH);
        rows = sb.clamp(sb.height_reg, MAX_HEIGHT);
        repeat (frames)
        begin
            for (int i = 0; i < cols * rows; i++)
            begin
                if ($urandom_range(0, 14) == 0)
                    push_word(pick_sample(), 1'b1);
                push_word(pick_sample(), 1'b0);
                sent++;
            end
            // A sample word during the drain is dropped and acts as a flush.
            while (sb.frame_taken)
            begin
                push_word(pick_sample(), $urandom_range(0, 3) != 0);
                sent++;
            end
        end
        for (int i = 0; i < partial; i++)
        begin
            push_word(pick_sample(), 1'b0);
            sent++;
        end
    endtask

    initial
    begin
        int r;
        int w;
        int h;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        sample = '0;
        flush = 1'b0;
        out_stall = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: extremes and an early flush, far too few words for a result.
        push_word(16'h8000, 1'b0);
        push_word(16'h7FFF, 1'b0);
        push_word(16'h0000, 1'b1);
        push_word(16'hFFFF, 1'b0);
        push_word(16'h0001, 1'b0);
        push_word(16'h5555, 1'b0);
        push_word(16'hAAAA, 1'b0);

        run_setting(1, 2, 2, 1, 0);
        run_setting(0, 0, 1, 2, 0);
        run_setting(15, 3, 3, 1, 0);
        run_setting(8, 1, 2047, 0, 20);
        run_setting(1, 2047, 2047, 0, 1030);
        run_setting(8, 6, 5, 1, 0);
        run_setting(2, 1024, 1, 0, 60);

        while (sent < RANDOM_SAMPLES)
        begin
            if (sent > RANDOM_SAMPLES - 200)
                quiet = 1;
            case ($urandom_range(0, 9))
                0:
                begin
                    r = $urandom_range(0, 1) ? 0 : $urandom_range(5, 15);
                    w = $urandom_range(1, 5);
                    h = $urandom_range(1, 5);
                end
                1, 2:
                begin
                    r = $urandom_range(3, 4);
                    w = $urandom_range(1, 7);
                    h = $urandom_range(1, 7);
                end
                default:
                begin
                    r = $urandom_range(1, 2);
                    w = $urandom_range(1, 10);
                    h = $urandom_range(1, 10);
                end
            endcase
            run_setting(r, w, h, $urandom_range(1, 2),
                        ($urandom_range(0, 5) == 0) ? $urandom_range(1, w * h) : 0);
        end

        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

/* files.f */
hdl/cwm_pkg.sv
hdl/cwm_ram.sv
hdl/cwm_front.sv
hdl/cwm_back.sv
hdl/circular_window_median_filter_unit.sv
tb/circular_window_median_filter_unit_test.sv
